>>> hdl/lnrc_pkg.sv
// Package for the labelled network rule check block.
// Types, opcodes, register indexes and sizing constants shared by the
// engine, the top, the checker and the testbench. No dependencies.
package lnrc_pkg;

  // Table size and derived widths
  localparam int RULE_SLOTS = 16;
  localparam int SLOT_W     = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int SLOT_ROWS  = 1 << SLOT_W;
  localparam int SIDE_ROWS  = 2 * SLOT_ROWS;

  // Config register indexes and reset values
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_MASK   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASK = 1'b1;
  localparam logic [31:0] LABEL_MASK_RST   = 32'hFFFF_FFFF;
  localparam logic [31:0] INVERSE_MASK_RST = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_WR_LOCAL   = 2'd0,
    OP_WR_REMOTE  = 2'd1,
    OP_CHK_LOCAL  = 2'd2,
    OP_CHK_REMOTE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } eng_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] label;
    logic [31:0] address;
    logic [31:0] address_mask;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [15:0] request_port;
  } in_t;

  typedef struct packed {
    logic allowed;
    logic label_restricted;
    logic rule_matched;
  } out_t;

  typedef struct packed {
    logic [31:0] label_match_mask;
    logic [31:0] inverse_flag_mask;
  } cfg_t;

  // One side of a rule row as stored in the side memory
  typedef struct packed {
    logic [31:0] address;
    logic [31:0] mask;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } side_t;

  // Engine to output stage handshake
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

>>> hdl/labelled_network_rule_check_top.sv
// Top level of the labelled network rule check block.
// Holds the config registers and the result register; depends on lnrc_pkg
// and lnrc_engine.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i / in_stall_o    lnrc_pkg::in_t
//   out      output     out_valid_o / out_stall_i  lnrc_pkg::out_t
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A write goes from idle straight to done in the engine; a check first scans
// all RULE_SLOTS slots, reading one slot per cycle from the label and side
// memories, then a drain state, before done. The result then moves into the
// output register, which holds it while out_stall_i is high and lets the
// engine start the next transaction. in_stall_o is high while the engine is
// busy. Reset clears all slot valid bits at once; no clearing pass.
module labelled_network_rule_check_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lnrc_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lnrc_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [lnrc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [31:0]                         cfg_wdata_i
);

  lnrc_pkg::cfg_t cfg_q;
  lnrc_pkg::res_t res;
  lnrc_pkg::out_t out_q;
  logic           out_valid_q;
  logic           eng_ready;
  logic           out_free;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.label_match_mask  <= lnrc_pkg::LABEL_MASK_RST;
      cfg_q.inverse_flag_mask <= lnrc_pkg::INVERSE_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lnrc_pkg::CFG_LABEL_MASK:   cfg_q.label_match_mask  <= cfg_wdata_i;
        lnrc_pkg::CFG_INVERSE_MASK: cfg_q.inverse_flag_mask <= cfg_wdata_i;
      endcase
    end
  end

  lnrc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (eng_ready),
    .req_i       (in_data_i),
    .res_o       (res),
    .res_ready_i (out_free)
  );

  assign in_stall_o = !eng_ready;

  // Output register: free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/lnrc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data is registered, so it appears in the cycle after the address. No dependencies.
module lnrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lnrc_engine.sv
// Rule table engine: label and side memories, slot valid bits and the
// sequencer that writes a row or scans all slots for a check.
// Depends on lnrc_pkg and lnrc_ram.
module lnrc_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lnrc_pkg::cfg_t    cfg_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  lnrc_pkg::in_t     req_i,
  output lnrc_pkg::res_t    res_o,
  input  logic              res_ready_i
);

  lnrc_pkg::eng_state_e state_q, state_d;

  logic [lnrc_pkg::SLOT_W-1:0]     cnt_q, cnt_d;
  logic [lnrc_pkg::SLOT_W-1:0]     pidx_q;
  logic                            pend_q;
  logic                            restr_q, restr_d;
  logic                            match_q, match_d;
  logic                            is_wr_q;
  lnrc_pkg::in_t                   req_q;
  logic [lnrc_pkg::RULE_SLOTS-1:0] slot_valid_q;

  logic                            accept;
  logic                            in_is_wr;
  logic                            wr_en;
  logic [lnrc_pkg::SLOT_W-1:0]     wr_slot;
  logic                            wr_side;
  logic                            rd_side;
  logic [31:0]                     lbl_rd;
  lnrc_pkg::side_t                 side_rd;
  lnrc_pkg::side_t                 side_wr;
  logic                            label_hit;
  logic                            side_hit;
  logic                            inverse;

  // Decode the incoming transaction
  assign accept   = req_valid_i && req_ready_o;
  assign in_is_wr = (req_i.operation == lnrc_pkg::OP_WR_LOCAL) ||
                    (req_i.operation == lnrc_pkg::OP_WR_REMOTE);
  assign wr_en    = accept && in_is_wr &&
                    (32'(req_i.entry_index) < lnrc_pkg::RULE_SLOTS);
  assign wr_slot  = lnrc_pkg::SLOT_W'(req_i.entry_index);
  assign wr_side  = (req_i.operation == lnrc_pkg::OP_WR_REMOTE);
  assign rd_side  = (req_q.operation == lnrc_pkg::OP_CHK_REMOTE);

  assign side_wr.address   = req_i.address;
  assign side_wr.mask      = req_i.address_mask;
  assign side_wr.port_low  = req_i.port_low;
  assign side_wr.port_high = req_i.port_high;

  // Label memory, one row per slot
  lnrc_ram #(
    .WIDTH (32),
    .DEPTH (lnrc_pkg::SLOT_ROWS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_slot),
    .wdata_i (req_i.label),
    .raddr_i (cnt_q),
    .rdata_o (lbl_rd)
  );

  // Side memory, addressed by {remote side, slot}
  lnrc_ram #(
    .WIDTH ($bits(lnrc_pkg::side_t)),
    .DEPTH (lnrc_pkg::SIDE_ROWS)
  ) u_side_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i ({wr_side, wr_slot}),
    .wdata_i (side_wr),
    .raddr_i ({rd_side, cnt_q}),
    .rdata_o (side_rd)
  );

  // Compare the slot whose row came back this cycle
  assign label_hit = slot_valid_q[pidx_q] &&
                     ((lbl_rd & cfg_i.label_match_mask) ==
                      (req_q.label & cfg_i.label_match_mask));
  assign side_hit  = (((req_q.address ^ side_rd.address) & side_rd.mask) == 32'd0) &&
                     (req_q.request_port >= side_rd.port_low) &&
                     (req_q.request_port <= side_rd.port_high);
  assign inverse   = |(req_q.label & cfg_i.inverse_flag_mask);

  // Next state, scan counter, accumulators and result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    restr_d     = restr_q;
    match_d     = match_q;
    req_ready_o = 1'b0;
    res_o       = '0;
    if (pend_q) begin
      restr_d = restr_q || label_hit;
      match_d = match_q || (label_hit && side_hit);
    end
    unique case (state_q)
      lnrc_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cnt_d   = '0;
          restr_d = 1'b0;
          match_d = 1'b0;
          state_d = in_is_wr ? lnrc_pkg::ST_DONE : lnrc_pkg::ST_SCAN;
        end
      end
      lnrc_pkg::ST_SCAN: begin
        if (cnt_q == lnrc_pkg::SLOT_W'(lnrc_pkg::RULE_SLOTS - 1)) begin
          state_d = lnrc_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lnrc_pkg::ST_DRAIN: begin
        state_d = lnrc_pkg::ST_DONE;
      end
      lnrc_pkg::ST_DONE: begin
        res_o.valid = 1'b1;
        if (!is_wr_q) begin
          res_o.data.label_restricted = restr_q;
          res_o.data.rule_matched     = match_q;
          res_o.data.allowed          = restr_q ? (match_q ^ inverse) : 1'b1;
        end
        if (res_ready_i) begin
          state_d = lnrc_pkg::ST_IDLE;
        end
      end
      default: state_d = lnrc_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lnrc_pkg::ST_IDLE;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      restr_q      <= 1'b0;
      match_q      <= 1'b0;
      slot_valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= (state_q == lnrc_pkg::ST_SCAN);
      restr_q <= restr_d;
      match_q <= match_d;
      if (wr_en) begin
        slot_valid_q[wr_slot] <= req_i.entry_valid;
      end
    end
  end

  // Held transaction and pending read index
  always_ff @(posedge clk_i) begin
    pidx_q <= cnt_q;
    if (accept) begin
      req_q   <= req_i;
      is_wr_q <= in_is_wr;
    end
  end

`ifndef ASSERT_OFF
  // The scan steps one slot per cycle until it reaches the last slot
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lnrc_pkg::ST_SCAN) |=>
      ((state_q == lnrc_pkg::ST_SCAN) && (cnt_q == $past(cnt_q) + 1'b1)) ||
      (state_q == lnrc_pkg::ST_DRAIN))
    else $error("scan counter skipped or scan left early");

  // A compare only happens on data read during the scan
  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(state_q == lnrc_pkg::ST_SCAN))
    else $error("compare outside of scan");

  // An accepted write goes straight to its result
  a_wr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_is_wr) |=> (state_q == lnrc_pkg::ST_DONE))
    else $error("write did not complete in one cycle");

  // An unrestricted check is always allowed
  a_unrestr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !is_wr_q && !res_o.data.label_restricted) |-> res_o.data.allowed)
    else $error("unrestricted label denied");
`endif

endmodule

>>> sim/lnrc_checker.sv
// Checker for the labelled network rule check block: watches the input, output
// and register write ports, keeps its own copy of the rule table and compares
// every result transaction. Depends on lnrc_pkg.
module lnrc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  lnrc_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  lnrc_pkg::out_t                 out_data_i,
  input  logic                           cfg_we_i,
  input  logic [lnrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_wdata_i,
  output int                             mismatches_o,
  output int                             outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the registers and the rule table; side 0 is local, 1 is remote
  logic [31:0]     grp_mask_q;
  logic [31:0]     inverse_mask_q;
  logic            slot_valid_q [lnrc_pkg::RULE_SLOTS];
  logic [31:0]     slot_label_q [lnrc_pkg::RULE_SLOTS];
  lnrc_pkg::side_t rule_side_q  [2][lnrc_pkg::RULE_SLOTS];

  lnrc_pkg::out_t verdict_q [$];
  int             mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  // Applies one transaction to the table and returns the verdict it yields
  function automatic lnrc_pkg::out_t apply_transaction(input lnrc_pkg::in_t t);
    lnrc_pkg::out_t  r;
    logic            side;
    lnrc_pkg::side_t cand;
    logic            hit;
    r    = '0;
    side = (t.operation == lnrc_pkg::OP_WR_REMOTE) ||
           (t.operation == lnrc_pkg::OP_CHK_REMOTE);
    if (t.operation == lnrc_pkg::OP_WR_LOCAL || t.operation == lnrc_pkg::OP_WR_REMOTE) begin
      if (int'(t.entry_index) < lnrc_pkg::RULE_SLOTS) begin
        slot_valid_q[t.entry_index]                = t.entry_valid;
        slot_label_q[t.entry_index]                = t.label;
        rule_side_q[side][t.entry_index].address   = t.address;
        rule_side_q[side][t.entry_index].mask      = t.address_mask;
        rule_side_q[side][t.entry_index].port_low  = t.port_low;
        rule_side_q[side][t.entry_index].port_high = t.port_high;
      end
      return r;
    end
    // Scan the label group on the requested side
    for (int i = 0; i < lnrc_pkg::RULE_SLOTS; i++) begin
      if (slot_valid_q[i] &&
          ((slot_label_q[i] & grp_mask_q) == (t.label & grp_mask_q))) begin
        r.label_restricted = 1'b1;
        cand = rule_side_q[side][i];
        hit  = ((t.address & cand.mask) == (cand.address & cand.mask)) &&
               (t.request_port >= cand.port_low) && (t.request_port <= cand.port_high);
        if (hit) r.rule_matched = 1'b1;
      end
    end
    if (!r.label_restricted) begin
      r.allowed = 1'b1;
    end else begin
      r.allowed = r.rule_matched ^ ((t.label & inverse_mask_q) != 32'd0);
    end
    return r;
  endfunction

  // Track transactions on all three ports
  always @(posedge clk_i or negedge rst_ni) begin
    lnrc_pkg::out_t expected;
    if (!rst_ni) begin
      grp_mask_q     = lnrc_pkg::LABEL_MASK_RST;
      inverse_mask_q = lnrc_pkg::INVERSE_MASK_RST;
      for (int i = 0; i < lnrc_pkg::RULE_SLOTS; i++) slot_valid_q[i] = 1'b0;
      verdict_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("result transaction with no verdict pending");
          mismatch_cnt++;
        end else begin
          expected = verdict_q.pop_front();
          if (out_data_i.allowed !== expected.allowed) begin
            $error("allowed: expected %0b, got %0b", expected.allowed, out_data_i.allowed);
            mismatch_cnt++;
          end
          if (out_data_i.label_restricted !== expected.label_restricted) begin
            $error("label_restricted: expected %0b, got %0b",
                   expected.label_restricted, out_data_i.label_restricted);
            mismatch_cnt++;
          end
          if (out_data_i.rule_matched !== expected.rule_matched) begin
            $error("rule_matched: expected %0b, got %0b",
                   expected.rule_matched, out_data_i.rule_matched);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) verdict_q.push_back(apply_transaction(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lnrc_pkg::CFG_LABEL_MASK:   grp_mask_q     = cfg_wdata_i;
          lnrc_pkg::CFG_INVERSE_MASK: inverse_mask_q = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    outstanding_o <= verdict_q.size();
  end

endmodule

>>> sim/labelled_network_rule_check_top_tb.sv
// Testbench top for labelled_network_rule_check_top: drives rule writes and
// access checks under random idling, steps through register settings and
// reports the verdict. Depends on lnrc_pkg, the block and lnrc_checker.
module labelled_network_rule_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  lnrc_pkg::in_t                  in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lnrc_pkg::out_t                 out_data;
  logic                           cfg_we    = 1'b0;
  logic [lnrc_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [31:0]                    cfg_wdata = '0;
  int                             mismatches;
  int                             outstanding;

  int gap_max   = 0;
  int stall_max = 0;

  // What the stimulus has written so far, used to aim checks at live rules
  logic            known_valid [lnrc_pkg::RULE_SLOTS];
  logic [31:0]     known_label [lnrc_pkg::RULE_SLOTS];
  lnrc_pkg::side_t known_side  [2][lnrc_pkg::RULE_SLOTS];
  logic [31:0]     label_pool  [6];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  labelled_network_rule_check_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  lnrc_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Result side: stall a random number of cycles in front of each result
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) hold = $urandom_range(0, stall_max);
      else if (out_valid && hold > 0) hold--;
      out_stall <= (hold > 0);
    end
  end

  function automatic lnrc_pkg::in_t build_item(input lnrc_pkg::op_e op,
                                               input logic [3:0] idx, input logic vld,
                                               input logic [31:0] lbl, input logic [31:0] addr,
                                               input logic [31:0] amask, input logic [15:0] plo,
                                               input logic [15:0] phi, input logic [15:0] rport);
    lnrc_pkg::in_t t;
    t.operation    = op;
    t.entry_index  = idx;
    t.entry_valid  = vld;
    t.label        = lbl;
    t.address      = addr;
    t.address_mask = amask;
    t.port_low     = plo;
    t.port_high    = phi;
    t.request_port = rport;
    return t;
  endfunction

  function automatic logic [31:0] pick_label();
    logic [31:0] l;
    l = label_pool[$urandom_range(0, 5)];
    if ($urandom_range(0, 3) == 0) l ^= $urandom() & $urandom();
    return l;
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 4))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFF << $urandom_range(0, 32);
      3:       return 32'hFFFF_FF00;
      default: return $urandom();
    endcase
  endfunction

  // Rule write with a random slot, label, mask and port range shape
  function automatic lnrc_pkg::in_t make_write();
    logic [15:0] a, b, lo, hi;
    a = 16'($urandom());
    b = 16'($urandom());
    case ($urandom_range(0, 4))
      0: begin lo = 16'h0000; hi = 16'hFFFF; end
      1: begin lo = a; hi = a; end
      2: begin lo = 16'($urandom_range(1, 65535)); hi = 16'($urandom_range(0, lo - 1)); end
      default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
    endcase
    return build_item($urandom_range(0, 1) ? lnrc_pkg::OP_WR_REMOTE : lnrc_pkg::OP_WR_LOCAL,
                      4'($urandom()), $urandom_range(0, 3) != 0, pick_label(), $urandom(),
                      pick_mask(), lo, hi, 16'($urandom()));
  endfunction

  // Access check, mostly aimed at a live rule so that groups and matches occur
  function automatic lnrc_pkg::in_t make_check();
    lnrc_pkg::in_t   t;
    int              s;
    logic            side;
    lnrc_pkg::side_t r;
    t = build_item($urandom_range(0, 1) ? lnrc_pkg::OP_CHK_REMOTE : lnrc_pkg::OP_CHK_LOCAL,
                   4'($urandom()), 1'($urandom()), pick_label(), $urandom(), $urandom(),
                   16'($urandom()), 16'($urandom()), 16'($urandom()));
    side = (t.operation == lnrc_pkg::OP_CHK_REMOTE);
    s    = $urandom_range(0, lnrc_pkg::RULE_SLOTS - 1);
    if (known_valid[s] && $urandom_range(0, 9) < 7) begin
      r       = known_side[side][s];
      t.label = known_label[s];
      if ($urandom_range(0, 3) == 0) t.label ^= 32'd1 << $urandom_range(0, 31);
      if ($urandom_range(0, 4) != 0) t.address = (r.address & r.mask) | (t.address & ~r.mask);
      case ($urandom_range(0, 4))
        3:       t.request_port = r.port_low - 16'd1;
        4:       t.request_port = r.port_high + 16'd1;
        default: t.request_port = 16'($urandom_range(r.port_high, r.port_low));
      endcase
    end
    return t;
  endfunction

  // One input transaction after a random gap
  task automatic send_transaction(input lnrc_pkg::in_t item);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (item.operation == lnrc_pkg::OP_WR_LOCAL || item.operation == lnrc_pkg::OP_WR_REMOTE) begin
      known_valid[item.entry_index] = item.entry_valid;
      known_label[item.entry_index] = item.label;
      known_side[item.operation == lnrc_pkg::OP_WR_REMOTE][item.entry_index] =
        '{address: item.address, mask: item.address_mask,
          port_low: item.port_low, port_high: item.port_high};
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_config(input logic [31:0] lbl_mask, input logic [31:0] inverse_mask);
    cfg_we    <= 1'b1;
    cfg_idx   <= lnrc_pkg::CFG_LABEL_MASK;
    cfg_wdata <= lbl_mask;
    @(posedge clk);
    cfg_idx   <= lnrc_pkg::CFG_INVERSE_MASK;
    cfg_wdata <= inverse_mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    lnrc_pkg::in_t t;
    logic [31:0]   grp;
    logic [31:0]   lmask, imask;
    grp = $urandom();
    label_pool[0] = 32'h0;
    label_pool[1] = 32'hFFFF_FFFF;
    label_pool[2] = grp;
    label_pool[3] = grp ^ 32'h0000_00FF;
    label_pool[4] = $urandom();
    label_pool[5] = $urandom();
    for (int i = 0; i < lnrc_pkg::RULE_SLOTS; i++) known_valid[i] = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both sides of every slot while it stays invalid
    gap_max   = 3;
    stall_max = 3;
    for (int s = 0; s < lnrc_pkg::RULE_SLOTS; s++) begin
      for (int side = 0; side < 2; side++) begin
        t             = make_write();
        t.operation   = side ? lnrc_pkg::OP_WR_REMOTE : lnrc_pkg::OP_WR_LOCAL;
        t.entry_index = 4'(s);
        t.entry_valid = 1'b0;
        send_transaction(t);
      end
    end

    // Directed: empty table, port edges, all-ones fields, empty range, any address
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, grp, $urandom(), 0, 0, 0,
                                16'($urandom())));
    send_transaction(build_item(lnrc_pkg::OP_CHK_REMOTE, 0, 0, '1, '1, 0, 0, 0, 16'hFFFF));
    send_transaction(build_item(lnrc_pkg::OP_WR_LOCAL, 0, 1, grp, 32'hC0A8_0100, 32'hFFFF_FF00,
                                16'd1000, 16'd2000, 0));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, grp, 32'hC0A8_01FF, 0, 0, 0,
                                16'd1000));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, grp, 32'hC0A8_0100, 0, 0, 0,
                                16'd2000));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, grp, 32'hC0A8_0101, 0, 0, 0,
                                16'd999));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, grp, 32'hC0A8_0101, 0, 0, 0,
                                16'd2001));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, grp, 32'hC0A8_0200, 0, 0, 0,
                                16'd1500));
    send_transaction(build_item(lnrc_pkg::OP_CHK_REMOTE, 0, 0, grp, $urandom(), 0, 0, 0,
                                16'($urandom())));
    send_transaction(build_item(lnrc_pkg::OP_WR_REMOTE, 15, 1, '1, '1, '1, 16'h0000, 16'hFFFF,
                                '1));
    send_transaction(build_item(lnrc_pkg::OP_CHK_REMOTE, 0, 0, '1, '1, 0, 0, 0, 16'hFFFF));
    send_transaction(build_item(lnrc_pkg::OP_CHK_REMOTE, 0, 0, '1, '1, 0, 0, 0, 16'h0000));
    send_transaction(build_item(lnrc_pkg::OP_CHK_REMOTE, 0, 0, '1, 32'hFFFF_FFFE, 0, 0, 0,
                                16'h0000));
    send_transaction(build_item(lnrc_pkg::OP_WR_REMOTE, 1, 1, grp, 0, 0, 16'd500, 16'd400, 0));
    send_transaction(build_item(lnrc_pkg::OP_CHK_REMOTE, 0, 0, grp, $urandom(), 0, 0, 0,
                                16'd450));
    send_transaction(build_item(lnrc_pkg::OP_WR_LOCAL, 2, 1, 0, 0, 0, 16'd80, 16'd80, 0));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, 0, $urandom(), 0, 0, 0, 16'd80));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, 0, $urandom(), 0, 0, 0, 16'd81));
    send_transaction(build_item(lnrc_pkg::OP_WR_LOCAL, 2, 0, 0, 0, 0, 16'd80, 16'd80, 0));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, 0, $urandom(), 0, 0, 0, 16'd80));
    send_transaction(build_item(lnrc_pkg::OP_WR_LOCAL, 0, 0, grp, 0, 0, 0, 0, 0));
    send_transaction(build_item(lnrc_pkg::OP_CHK_LOCAL, 0, 0, grp, $urandom(), 0, 0, 0,
                                16'($urandom())));
    wait_for_results();

    // Random phases, each under its own register setting and one of several idling patterns
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin lmask = 32'hFFFF_FFFF; imask = 32'h8000_0000; end
        1:       begin lmask = 32'hFFFF_0000; imask = 32'hFFFF_FFFF; end
        2:       begin lmask = 32'h0000_0000; imask = 32'h0000_0000; end
        3:       begin lmask = $urandom();    imask = 32'd1 << $urandom_range(0, 31); end
        4:       begin lmask = 32'hFFFF_FFFF; imask = 32'h0000_0000; end
        default: begin lmask = $urandom();    imask = $urandom(); end
      endcase
      set_config(lmask, imask);
      gap_max   = (phase % 3 == 2) ? 0 : 10;
      stall_max = (phase % 2 == 1) ? 0 : 10;
      if (phase == 5) gap_max = 0;
      repeat (108) begin
        if ($urandom_range(0, 99) == 0) wait_for_results();
        send_transaction(($urandom_range(0, 9) < 3) ? make_write() : make_check());
      end
      wait_for_results();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[labelled_network_rule_check_top] OK");
    end else begin
      $display("[labelled_network_rule_check_top] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("[labelled_network_rule_check_top] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/lnrc_pkg.sv
hdl/lnrc_ram.sv
hdl/lnrc_engine.sv
hdl/labelled_network_rule_check_top.sv
sim/lnrc_checker.sv
sim/labelled_network_rule_check_top_tb.sv
